// File: sv/gsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared types and constants of the grid relaxation unit.
// ----------------------------------------------------------------------------
package gsr_pkg;

	localparam int ACC_W  = 48;   // working width of sums and products
	localparam int QDEPTH = 4;    // front-to-back item queue depth
	localparam int QPW    = 2;    // queue pointer width

	localparam logic [2:0] REG_GRID_SIZE      = 3'd0;
	localparam logic [2:0] REG_COEFF_A        = 3'd1;
	localparam logic [2:0] REG_INVERSE_CENTER = 3'd2;
	localparam logic [2:0] REG_ITERATIONS     = 3'd3;
	localparam logic [2:0] REG_BOUNDARY_MODE  = 3'd4;

	localparam logic [1:0] BM_NEG_LR = 2'd1;
	localparam logic [1:0] BM_NEG_TB = 2'd2;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [1:0] {
		OP_WR_SOL = 2'd0,
		OP_WR_SRC = 2'd1,
		OP_READ   = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BP_TB = 2'd0,
		BP_LR = 2'd1,
		BP_CN = 2'd2
	} bphase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_RESULT,
		ST_C_RD,
		ST_C_S1,
		ST_C_M1,
		ST_C_S2,
		ST_C_M2,
		ST_C_WR,
		ST_B_RA,
		ST_B_RB,
		ST_B_WR
	} state_t;

	typedef struct packed {
		op_t                op;
		logic               on_grid;
		logic [5:0]         col;
		logic [5:0]         row;
		logic signed [31:0] value;
	} q_item_t;

	typedef struct packed {
		logic [6:0]  grid_size;
		logic [30:0] coeff_a;
		logic [30:0] inverse_center;
		logic [7:0]  iterations;
		logic [1:0]  boundary_mode;
	} cfg_t;

endpackage

// File: sv/gsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_front
// Accepts input transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module gsr_front import gsr_pkg::*; #(
	parameter int MAX_GRID = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // op[1:0], col[7:2], row[13:8], value[45:14]
	output logic        q_valid,
	input  logic        q_ready,
	output q_item_t     q_item
);

	q_item_t          entry_q [QDEPTH];
	logic [QPW-1:0]   wp_q, rp_q;
	logic [QPW:0]     cnt_q;
	q_item_t          item_in;
	logic             push, pop;

	always_comb begin
		item_in.op      = op_t'(s_tdata[1:0]);
		item_in.col     = s_tdata[7:2];
		item_in.row     = s_tdata[13:8];
		item_in.value   = $signed(s_tdata[45:14]);
		item_in.on_grid = (int'(s_tdata[7:2]) < MAX_GRID) && (int'(s_tdata[13:8]) < MAX_GRID);
	end

	assign s_tready = (cnt_q != (QPW+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = entry_q[rp_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPW+1)'(1);
			end
		end
	end

endmodule

// File: sv/gsr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_mul
// Q16.16 coefficient times 48-bit signed operand, 16 operand bits per cycle.
// ----------------------------------------------------------------------------
module gsr_mul import gsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [30:0]             coef,
	input  logic signed [ACC_W-1:0] opnd,
	output logic                    busy,
	output logic signed [63:0]      res    // floor(coef * opnd / 2^16)
);

	logic                    busy_q;
	logic [1:0]              cnt_q;
	logic [30:0]             coef_q;
	logic signed [ACC_W-1:0] opnd_q;
	logic signed [79:0]      acc_q;
	logic signed [16:0]      chunk;
	logic signed [48:0]      prod;

	always_comb begin
		if (cnt_q == 2'd2) begin
			chunk = $signed({opnd_q[47], opnd_q[47:32]});
		end else begin
			chunk = $signed({1'b0, opnd_q[{cnt_q, 4'b0000} +: 16]});
		end
		prod = chunk * $signed({1'b0, coef_q});
	end

	assign busy = busy_q;
	assign res  = $signed(acc_q[79:16]);

	always_ff @(posedge clk) begin
		if (start) begin
			coef_q <= coef;
			opnd_q <= opnd;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (80'(prod) <<< {cnt_q, 4'b0000});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd2) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/gsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_back
// Grid memories and the sequencer for loads, reads and relaxation sweeps.
// ----------------------------------------------------------------------------
module gsr_back import gsr_pkg::*; #(
	parameter int MAX_GRID    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	output logic        q_ready,
	input  q_item_t     q_item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // data[31:0]
	output logic [0:0]  m_tuser    // kind[0]
);

	localparam int CW    = $clog2(MAX_GRID);
	localparam int NW    = $clog2(MAX_GRID + 1);
	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = VALUE_WIDTH;

	function automatic logic signed [VW-1:0] sat_vw(input logic signed [63:0] v);
		logic signed [63:0] hi, lo;
		hi = (64'sd1 <<< (VW - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) sat_vw = VW'(hi);
		else if (v < lo) sat_vw = VW'(lo);
		else sat_vw = VW'(v);
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] v);
		logic signed [63:0] hi, lo;
		hi = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) sat_acc = ACC_W'(hi);
		else if (v < lo) sat_acc = ACC_W'(lo);
		else sat_acc = ACC_W'(v);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) sat32 = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648) sat32 = 32'h8000_0000;
		else sat32 = v[31:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] cc, input logic [CW-1:0] rr);
		addr_of = AW'(rr) * AW'(MAX_GRID) + AW'(cc);
	endfunction

	logic signed [VW-1:0] sol_mem [DEPTH];
	logic signed [VW-1:0] src_mem [DEPTH];

	state_t               state_q, state_nxt;
	logic [CW-1:0]        c_q, r_q, bk_q;
	logic [2:0]           ph_q;
	logic signed [63:0]   sum_q;
	logic [7:0]           it_q;
	bphase_t              bph_q;
	logic                 bw_q;
	logic signed [VW-1:0] va_q, sol_rdata_q, src_rdata_q;
	logic                 rd_inside_q;
	logic                 res_kind_q, out_kind_q, out_valid_q;
	logic [31:0]          res_data_q, out_data_q;

	logic                 sol_we, sol_re, src_we, src_re;
	logic [AW-1:0]        sol_waddr, sol_raddr, src_waddr, src_raddr;
	logic signed [VW-1:0] sol_wdata, src_wdata, bval;
	logic                 mul_start, mul_busy;
	logic [30:0]          mul_coef;
	logic signed [ACC_W-1:0] mul_opnd;
	logic signed [63:0]   mul_res;

	logic [NW-1:0]        n_w;
	logic [CW-1:0]        nm2, nm3;
	logic [AW-1:0]        item_addr, nb_addr;
	logic [CW-1:0]        a_c, a_r, b_c, b_r, d_c, d_r;
	logic                 neg, halve, last_it, sweep_end, bnd_end;

	gsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.coef   (mul_coef),
		.opnd   (mul_opnd),
		.busy   (mul_busy),
		.res    (mul_res)
	);

	// effective grid size
	always_comb begin
		if (cfg.grid_size < 7'd6) begin
			n_w = NW'(6);
		end else if (int'(cfg.grid_size) > MAX_GRID) begin
			n_w = NW'(MAX_GRID);
		end else begin
			n_w = NW'(cfg.grid_size);
		end
		nm2 = CW'(n_w - NW'(2));
		nm3 = CW'(n_w - NW'(3));
	end

	assign item_addr = addr_of(CW'(q_item.col), CW'(q_item.row));
	assign last_it   = ({1'b0, it_q} + 9'd1) == {1'b0, cfg.iterations};
	assign sweep_end = (c_q == nm3) && (r_q == nm3);
	assign bnd_end   = (bph_q == BP_CN) && (bk_q == CW'(3));

	always_comb begin
		unique case (ph_q)
			3'd0:    nb_addr = addr_of(c_q + CW'(1), r_q);
			3'd1:    nb_addr = addr_of(c_q - CW'(1), r_q);
			3'd2:    nb_addr = addr_of(c_q, r_q + CW'(1));
			default: nb_addr = addr_of(c_q, r_q - CW'(1));
		endcase
	end

	// boundary step: sources A and B, destination D
	always_comb begin
		a_c = bk_q; a_r = bk_q; d_c = bk_q; d_r = bk_q;
		neg = 1'b0; halve = 1'b0;
		case (bph_q)
			BP_TB: begin
				a_r = bw_q ? nm3 : CW'(2);
				d_r = bw_q ? nm2 : CW'(1);
				neg = (cfg.boundary_mode == BM_NEG_TB);
			end
			BP_LR: begin
				a_c = bw_q ? nm3 : CW'(2);
				d_c = bw_q ? nm2 : CW'(1);
				neg = (cfg.boundary_mode == BM_NEG_LR);
			end
			BP_CN: begin
				halve = 1'b1;
				unique case (bk_q[1:0])
					2'd0: begin
						a_c = CW'(1); a_r = '0; d_c = CW'(1); d_r = CW'(1);
					end
					2'd1: begin
						a_c = CW'(1); a_r = nm2; d_c = CW'(1); d_r = nm2;
					end
					2'd2: begin
						a_c = nm3; a_r = '0; d_c = nm2; d_r = CW'(1);
					end
					default: begin
						a_c = nm3; a_r = nm2; d_c = nm2; d_r = nm2;
					end
				endcase
			end
			default: ;
		endcase
		b_c = a_c; b_r = a_r;
		if (bph_q == BP_CN) begin
			unique case (bk_q[1:0])
				2'd0:    begin b_c = '0;  b_r = CW'(1); end
				2'd1:    begin b_c = '0;  b_r = nm3;    end
				2'd2:    begin b_c = nm2; b_r = CW'(1); end
				default: begin b_c = nm2; b_r = nm3;    end
			endcase
		end
		if (halve) begin
			bval = VW'((64'(va_q) + 64'(sol_rdata_q)) >>> 1);
		end else if (neg) begin
			bval = sat_vw(-64'(va_q));
		end else begin
			bval = va_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == OP_READ) begin
						state_nxt = ST_RD_WAIT;
					end else if (q_item.op == OP_RUN) begin
						state_nxt = (cfg.iterations == 8'd0) ? ST_RESULT : ST_C_RD;
					end
				end
			end
			ST_RD_WAIT: state_nxt = ST_RESULT;
			ST_RESULT:  if (!out_valid_q || m_tready) state_nxt = ST_IDLE;
			ST_C_RD:    if (ph_q == 3'd4) state_nxt = ST_C_S1;
			ST_C_S1:    state_nxt = ST_C_M1;
			ST_C_M1:    if (!mul_busy) state_nxt = ST_C_S2;
			ST_C_S2:    state_nxt = ST_C_M2;
			ST_C_M2:    if (!mul_busy) state_nxt = ST_C_WR;
			ST_C_WR:    state_nxt = sweep_end ? ST_B_RA : ST_C_RD;
			ST_B_RA:    state_nxt = ST_B_RB;
			ST_B_RB:    state_nxt = ST_B_WR;
			ST_B_WR: begin
				if (bnd_end) begin
					state_nxt = last_it ? ST_RESULT : ST_C_RD;
				end else begin
					state_nxt = ST_B_RA;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready   = 1'b0;
		sol_we    = 1'b0; sol_waddr = '0; sol_wdata = '0;
		src_we    = 1'b0; src_waddr = '0; src_wdata = '0;
		sol_re    = 1'b0; sol_raddr = '0;
		src_re    = 1'b0; src_raddr = '0;
		mul_start = 1'b0; mul_coef = '0; mul_opnd = '0;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					unique case (q_item.op)
						OP_WR_SOL: begin
							sol_we    = q_item.on_grid;
							sol_waddr = item_addr;
							sol_wdata = sat_vw(64'(q_item.value));
						end
						OP_WR_SRC: begin
							src_we    = q_item.on_grid;
							src_waddr = item_addr;
							src_wdata = sat_vw(64'(q_item.value));
						end
						OP_READ: begin
							sol_re    = 1'b1;
							sol_raddr = item_addr;
						end
						default: ;
					endcase
				end
			end
			ST_C_RD: begin
				if (ph_q != 3'd4) begin
					sol_re    = 1'b1;
					sol_raddr = nb_addr;
				end
				if (ph_q == 3'd0) begin
					src_re    = 1'b1;
					src_raddr = addr_of(c_q, r_q);
				end
			end
			ST_C_S1: begin
				mul_start = 1'b1;
				mul_coef  = cfg.coeff_a;
				mul_opnd  = sat_acc(sum_q);
			end
			ST_C_S2: begin
				mul_start = 1'b1;
				mul_coef  = cfg.inverse_center;
				mul_opnd  = sat_acc(64'(src_rdata_q) + mul_res);
			end
			ST_C_WR: begin
				sol_we    = 1'b1;
				sol_waddr = addr_of(c_q, r_q);
				sol_wdata = sat_vw(mul_res);
			end
			ST_B_RA: begin
				sol_re    = 1'b1;
				sol_raddr = addr_of(a_c, a_r);
			end
			ST_B_RB: begin
				sol_re    = 1'b1;
				sol_raddr = addr_of(b_c, b_r);
			end
			ST_B_WR: begin
				sol_we    = 1'b1;
				sol_waddr = addr_of(d_c, d_r);
				sol_wdata = bval;
			end
			default: ;
		endcase
	end

	// grid memories
	always_ff @(posedge clk) begin
		if (sol_we) sol_mem[sol_waddr] <= sol_wdata;
		if (sol_re) sol_rdata_q <= sol_mem[sol_raddr];
	end

	always_ff @(posedge clk) begin
		if (src_we) src_mem[src_waddr] <= src_wdata;
		if (src_re) src_rdata_q <= src_mem[src_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rd_inside_q <= q_item.on_grid;
				res_kind_q  <= KIND_DONE;
				res_data_q  <= '0;
			end
			ST_RD_WAIT: begin
				res_kind_q <= KIND_READ;
				res_data_q <= rd_inside_q ? sat32(64'(sol_rdata_q)) : '0;
			end
			ST_C_RD: begin
				if (ph_q == 3'd0) sum_q <= '0;
				else sum_q <= sum_q + 64'(sol_rdata_q);
			end
			ST_B_RB: va_q <= sol_rdata_q;
			default: ;
		endcase
		if (state_q == ST_RESULT && (!out_valid_q || m_tready)) begin
			out_kind_q <= res_kind_q;
			out_data_q <= res_data_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			c_q         <= '0;
			r_q         <= '0;
			ph_q        <= '0;
			it_q        <= '0;
			bph_q       <= BP_TB;
			bk_q        <= '0;
			bw_q        <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RESULT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					it_q <= '0;
					c_q  <= CW'(2);
					r_q  <= CW'(2);
					ph_q <= '0;
				end
				ST_C_RD: begin
					ph_q <= (ph_q == 3'd4) ? 3'd0 : ph_q + 3'd1;
				end
				ST_C_WR: begin
					if (c_q == nm3) begin
						c_q <= CW'(2);
						if (r_q == nm3) begin
							bph_q <= BP_TB;
							bk_q  <= CW'(1);
							bw_q  <= 1'b0;
						end else begin
							r_q <= r_q + CW'(1);
						end
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				ST_B_WR: begin
					case (bph_q)
						BP_TB, BP_LR: begin
							if (!bw_q) begin
								bw_q <= 1'b1;
							end else begin
								bw_q <= 1'b0;
								if (bk_q == nm3) begin
									bph_q <= (bph_q == BP_TB) ? BP_LR : BP_CN;
									bk_q  <= (bph_q == BP_TB) ? CW'(1) : '0;
								end else begin
									bk_q <= bk_q + CW'(1);
								end
							end
						end
						BP_CN: begin
							if (bk_q == CW'(3)) begin
								it_q <= it_q + 8'd1;
								c_q  <= CW'(2);
								r_q  <= CW'(2);
								ph_q <= '0;
							end else begin
								bk_q <= bk_q + CW'(1);
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

// File: sv/gauss_seidel_grid_relax_unit.sv
`timescale 1ns / 1ps
// With the back end idle, a cell load is written to its grid as it leaves the queue; a read
// result passes the memory read register, the result register and the output register.
// A run repeats, iterations times, an interior sweep of (N-4)^2 cells, N the grid size,
// and the border rule; per cell five memory reads, two 3-step multiplies, one write back.
// One item is worked on at a time; a 4-entry queue keeps accepting meanwhile until it is full.
// Reset empties the queue, resets the sequencer and the output valid flag and loads the register
// defaults; grid memories are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
// gauss_seidel_grid_relax_unit
// Gauss-Seidel relaxation over a Q16.16 solution grid with a source grid.
// ----------------------------------------------------------------------------
module gauss_seidel_grid_relax_unit import gsr_pkg::*; #(
	parameter int MAX_GRID    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // op[1:0], col[7:2], row[13:8], value[45:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // data[31:0]
	output logic [0:0]  m_tuser,    // kind[0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	cfg_t    cfg_q;
	logic    q_valid, q_ready;
	q_item_t q_item;

	// configuration registers; the user must write them only while the unit is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size      <= 7'd64;
			cfg_q.coeff_a        <= 31'd65536;
			cfg_q.inverse_center <= 31'd10923;
			cfg_q.iterations     <= 8'd20;
			cfg_q.boundary_mode  <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SIZE:      cfg_q.grid_size      <= cfg_wdata[6:0];
				REG_COEFF_A:        cfg_q.coeff_a        <= cfg_wdata;
				REG_INVERSE_CENTER: cfg_q.inverse_center <= cfg_wdata;
				REG_ITERATIONS:     cfg_q.iterations     <= cfg_wdata[7:0];
				REG_BOUNDARY_MODE:  cfg_q.boundary_mode  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// front: takes transactions, decodes op and range, queues them
	gsr_front #(
		.MAX_GRID (MAX_GRID)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// back: memories, sweep sequencer, result register
	gsr_back #(
		.MAX_GRID    (MAX_GRID),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a cell load never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && (q_item.op == OP_WR_SOL || q_item.op == OP_WR_SRC))
		|=> !$rose(m_tvalid))
		else $error("result raised after a cell load");

	// the front only back-pressures when it holds queued work
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with empty queue");

	// a read occupies the back end for the following cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_item.op == OP_READ) |=> !q_ready)
		else $error("back end free right after a read");

endmodule

// File: tb/gauss_seidel_grid_relax_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_grid_relax_unit_test
// Self-checking bench: loads the low corner of both grids, walks a directed
// table, then runs random load/read/run traffic over a series of register
// settings. A cycle-free Q16.16 relaxation predictor supplies every expected
// read and completion; results are matched in order against the output stream.
// ----------------------------------------------------------------------------
module gauss_seidel_grid_relax_unit_test;
	import gsr_pkg::*;

	localparam int MAXG = 64;
	localparam int VW   = 32;
	localparam int FILL = 13;   // preloaded square; runs and random reads stay inside it

	// ---- DUT signals -------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;      // op[1:0], col[7:2], row[13:8], value[45:14]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // data[31:0]
	logic [0:0]  m_tuser;           // kind[0]
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [30:0] cfg_wdata = '0;

	gauss_seidel_grid_relax_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// ---- shadow state of the unit ------------------------------------------
	longint sol_grid [MAXG*MAXG];
	longint src_grid [MAXG*MAXG];
	logic [6:0]  sh_size = 7'd64;
	logic [30:0] sh_a    = 31'd65536;
	logic [30:0] sh_ic   = 31'd10923;
	logic [7:0]  sh_iter = 8'd20;
	logic [1:0]  sh_bm   = 2'd0;

	typedef struct {
		logic        kind;
		logic [31:0] data;
	} outcome_t;

	outcome_t pending_results [$];
	int errors = 0;
	int n_results = 0;
	int n_runs = 0;
	int n_items = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// ---- Q16.16 arithmetic -------------------------------------------------
	function automatic longint sat(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// floor(coef * v / 2^16); arithmetic shift of a signed value is a floor
	function automatic longint mul_q16(input longint coef, input longint v);
		longint hi, lo;
		hi = coef >>> 16;
		lo = coef & 64'hFFFF;
		return hi * v + ((lo * v) >>> 16);
	endfunction

	function automatic int cidx(input int c, input int r, input int n);
		c = (c < 0) ? 0 : ((c >= n) ? n - 1 : c);
		r = (r < 0) ? 0 : ((r >= n) ? n - 1 : r);
		return r * MAXG + c;
	endfunction

	function automatic longint neg_if(input longint v, input bit neg);
		return neg ? sat(-v, VW) : v;
	endfunction

	function automatic longint halve(input longint p, input longint q);
		return sat((p + q) >>> 1, VW);
	endfunction

	// In-place sweeps followed by the edge/corner rule, as the block does it.
	task automatic relax_grid();
		int n, it, r, c, k;
		longint s, t;
		bit ntb, nlr;
		n = sh_size;
		if (n < 6) n = 6;
		if (n > MAXG) n = MAXG;
		ntb = (sh_bm == BM_NEG_TB);
		nlr = (sh_bm == BM_NEG_LR);
		for (it = 0; it < sh_iter; it++) begin
			for (r = 2; r < n - 2; r++) begin
				for (c = 2; c < n - 2; c++) begin
					s = sol_grid[cidx(c+1, r, n)] + sol_grid[cidx(c-1, r, n)]
					  + sol_grid[cidx(c, r+1, n)] + sol_grid[cidx(c, r-1, n)];
					s = sat(s, ACC_W);
					t = sat(src_grid[cidx(c, r, n)] + mul_q16(sh_a, s), ACC_W);
					sol_grid[cidx(c, r, n)] = sat(mul_q16(sh_ic, t), VW);
				end
			end
			for (k = 1; k < n - 2; k++) begin
				sol_grid[cidx(k, 1, n)]   = neg_if(sol_grid[cidx(k, 2, n)], ntb);
				sol_grid[cidx(k, n-2, n)] = neg_if(sol_grid[cidx(k, n-3, n)], ntb);
			end
			for (k = 1; k < n - 2; k++) begin
				sol_grid[cidx(1, k, n)]   = neg_if(sol_grid[cidx(2, k, n)], nlr);
				sol_grid[cidx(n-2, k, n)] = neg_if(sol_grid[cidx(n-3, k, n)], nlr);
			end
			sol_grid[cidx(1, 1, n)] =
				halve(sol_grid[cidx(1, 0, n)], sol_grid[cidx(0, 1, n)]);
			sol_grid[cidx(1, n-2, n)] =
				halve(sol_grid[cidx(1, n-2, n)], sol_grid[cidx(0, n-3, n)]);
			sol_grid[cidx(n-2, 1, n)] =
				halve(sol_grid[cidx(n-3, 0, n)], sol_grid[cidx(n-2, 1, n)]);
			sol_grid[cidx(n-2, n-2, n)] =
				halve(sol_grid[cidx(n-3, n-2, n)], sol_grid[cidx(n-2, n-3, n)]);
		end
	endtask

	// Apply one accepted transaction; returns 1 with the outcome if it yields one.
	task automatic predict_item(input op_t op, input logic [5:0] col, input logic [5:0] row,
			input logic [31:0] value, output bit has, output outcome_t o);
		int idx;
		idx = row * MAXG + col;
		has = 1'b0;
		o.kind = KIND_READ;
		o.data = '0;
		case (op)
			OP_WR_SOL: sol_grid[idx] = longint'($signed(value));
			OP_WR_SRC: src_grid[idx] = longint'($signed(value));
			OP_READ: begin
				has = 1'b1;
				o.data = sat(sol_grid[idx], 32);
			end
			default: begin
				relax_grid();
				has = 1'b1;
				o.kind = KIND_DONE;
				n_runs++;
			end
		endcase
	endtask

	// ---- output monitor: sampled at the rising edge --------------------------
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d data=%h",
					m_tuser[0], m_tdata));
			end else begin
				e = pending_results.pop_front();
				if (m_tuser[0] !== e.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", m_tuser[0], e.kind));
				if (m_tdata !== e.data)
					report_mismatch($sformatf("data %h, expected %h", m_tdata, e.data));
			end
		end
	end

	// ---- receiver: stall pattern redrawn among three modes -------------------
	// One long hold-off after a couple hundred results lets the item queue
	// back up behind a pending read so s_tready has to drop.
	initial begin
		int rmode, rcnt, hold;
		bit held;
		rmode = 0; rcnt = 0; hold = 0; held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!held && n_results >= 200) begin
				held = 1'b1;
				hold = 400;
				m_tready <= 1'b0;
			end else begin
				if (rcnt == 0) begin
					rmode = $urandom_range(0, 2);
					rcnt = 64;
				end
				rcnt--;
				case (rmode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---- sender -------------------------------------------------------------
	int burst_left = 0;

	task automatic send_item(input op_t op, input logic [5:0] col, input logic [5:0] row,
			input logic [31:0] value, output outcome_t o, output bit has);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, value, row, col, op};
		do @(posedge clk); while (!s_tready);
		n_items++;
		predict_item(op, col, row, value, has, o);
		if (has) pending_results.push_back(o);
	endtask

	// Wait for the stream to go quiet; loads produce no result, so allow
	// the queue of trailing loads time to commit.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_GRID_SIZE:      sh_size = val[6:0];
			REG_COEFF_A:        sh_a    = val;
			REG_INVERSE_CENTER: sh_ic   = val;
			REG_ITERATIONS:     sh_iter = val[7:0];
			default:            sh_bm   = val[1:0];
		endcase
	endtask

	task automatic set_config(input logic [6:0] n, input logic [30:0] a,
			input logic [30:0] ic, input logic [7:0] it, input logic [1:0] bm);
		write_reg(REG_GRID_SIZE, 31'(n));
		write_reg(REG_COEFF_A, a);
		write_reg(REG_INVERSE_CENTER, ic);
		write_reg(REG_ITERATIONS, 31'(it));
		write_reg(REG_BOUNDARY_MODE, 31'(bm));
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// ---- directed table: run with zero iterations, grid corners, extremes ----
	typedef struct {
		op_t         op;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [31:0] value;
		bit          chk;
		logic        kind;
		logic [31:0] data;
	} dir_row_t;

	localparam int NDIR = 16;
	dir_row_t dir_tab [NDIR] = '{
		'{OP_WR_SOL,  0,  0, 32'h7FFF_FFFF, 0, KIND_READ, 32'h0},
		'{OP_READ,    0,  0, 32'h0,         1, KIND_READ, 32'h7FFF_FFFF},
		'{OP_WR_SOL, 63, 63, 32'h8000_0000, 0, KIND_READ, 32'h0},
		'{OP_READ,   63, 63, 32'h0,         1, KIND_READ, 32'h8000_0000},
		'{OP_WR_SRC, 63,  0, 32'h7FFF_FFFF, 0, KIND_READ, 32'h0},
		'{OP_WR_SRC,  0, 63, 32'h8000_0000, 0, KIND_READ, 32'h0},
		'{OP_WR_SOL, 40, 20, 32'h0001_0000, 0, KIND_READ, 32'h0},   // beyond N, still stored
		'{OP_READ,   40, 20, 32'h0,         1, KIND_READ, 32'h0001_0000},
		'{OP_RUN,     0,  0, 32'h0,         1, KIND_DONE, 32'h0},   // zero sweeps
		'{OP_READ,    0,  0, 32'h0,         1, KIND_READ, 32'h7FFF_FFFF},
		'{OP_WR_SOL,  2,  2, 32'h0,         0, KIND_READ, 32'h0},
		'{OP_READ,    2,  2, 32'h0,         1, KIND_READ, 32'h0},
		'{OP_WR_SOL,  3,  3, 32'hFFFF_FFFF, 0, KIND_READ, 32'h0},
		'{OP_READ,    3,  3, 32'h0,         1, KIND_READ, 32'hFFFF_FFFF},
		'{OP_WR_SRC,  5,  7, 32'h5555_AAAA, 0, KIND_READ, 32'h0},
		'{OP_READ,    5,  7, 32'h0,         0, KIND_READ, 32'h0}
	};

	// ---- register settings per phase: size, a, 1/c, sweeps, mode, items, run % --
	typedef struct {
		logic [6:0]  n;
		logic [30:0] a;
		logic [30:0] ic;
		logic [7:0]  it;
		logic [1:0]  bm;
		int          items;
		int          run_pct;
	} phase_t;

	localparam int NFIX = 6;
	localparam int NRND = 4;
	phase_t fixed_phases [NFIX] = '{
		'{7'd8,   31'd16384,      31'd32768,      8'd3,   2'd1, 150, 5},
		'{7'd10,  31'd0,          31'd65536,      8'd2,   2'd2, 150, 4},
		'{7'd0,   31'h7FFF_FFFF,  31'h7FFF_FFFF,  8'd255, 2'd0, 100, 2},  // size below 6
		'{7'd12,  31'd20000,      31'd30000,      8'd1,   2'd3,  40, 0},  // mode 3 copies
		'{7'd64,  31'd65536,      31'd0,          8'd0,   2'd2,  60, 10},
		'{7'd6,   31'h7FFF_FFFF,  31'd65536,      8'd4,   2'd1, 100, 8}
	};

	initial begin
		outcome_t o;
		bit has;
		phase_t ph;
		int i, k, r;
		op_t op;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the corner square of both grids; runs and random reads never leave it.
		for (r = 0; r < FILL; r++) begin
			for (i = 0; i < FILL; i++) begin
				send_item(OP_WR_SOL, 6'(i), 6'(r), rand_value(), o, has);
				send_item(OP_WR_SRC, 6'(i), 6'(r), rand_value(), o, has);
			end
		end
		drain();
		set_config(7'd6, 31'd65536, 31'd10923, 8'd0, 2'd0);

		for (i = 0; i < NDIR; i++) begin
			send_item(dir_tab[i].op, dir_tab[i].col, dir_tab[i].row, dir_tab[i].value,
				o, has);
			if (dir_tab[i].chk && (!has || o.kind !== dir_tab[i].kind
					|| o.data !== dir_tab[i].data))
				report_mismatch($sformatf("directed row %0d predicts %0d/%h", i,
					o.kind, o.data));
		end

		// Fixed corner settings first, then random small grids.
		for (k = 0; k < NFIX + NRND; k++) begin
			if (k < NFIX) begin
				ph = fixed_phases[k];
			end else begin
				ph.n = 7'($urandom_range(6, FILL - 1));
				ph.a = 31'($urandom_range(0, 131072));
				ph.ic = 31'($urandom_range(0, 65536));
				ph.it = 8'($urandom_range(1, 6));
				ph.bm = 2'($urandom_range(0, 3));
				ph.items = 150;
				ph.run_pct = 4;
			end
			drain();
			set_config(ph.n, ph.a, ph.ic, ph.it, ph.bm);
			for (i = 0; i < ph.items; i++) begin
				r = $urandom_range(0, 99);
				if (r < ph.run_pct) op = OP_RUN;
				else if (r < ph.run_pct + 30) op = OP_READ;
				else if (r < ph.run_pct + 65) op = OP_WR_SOL;
				else op = OP_WR_SRC;
				if (op == OP_READ)
					send_item(op, 6'($urandom_range(0, FILL - 1)),
						6'($urandom_range(0, FILL - 1)), rand_value(), o, has);
				else
					send_item(op, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
						rand_value(), o, has);
			end
			// every setting ends with a run and four reads inside the filled square
			send_item(OP_RUN, '0, '0, $urandom, o, has);
			for (i = 0; i < 4; i++)
				send_item(OP_READ, 6'($urandom_range(0, 12)), 6'($urandom_range(0, 12)),
					$urandom, o, has);
		end

		drain();
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("Covered %0d transactions in, %0d results out, %0d relaxation runs,",
			n_items, n_results, n_runs);
		$display("over %0d register settings including size, weight and mode extremes.",
			NFIX + NRND + 1);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// ---- watchdog ------------------------------------------------------------
	initial begin
		#50000000;
		$display("TIMEOUT: stream stalled");
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: gauss_seidel_grid_relax_unit.f
sv/gsr_pkg.sv
sv/gsr_front.sv
sv/gsr_mul.sv
sv/gsr_back.sv
sv/gauss_seidel_grid_relax_unit.sv
tb/gauss_seidel_grid_relax_unit_test.sv
